### src/brfs_pkg.sv
// ----------------------------------------------------------------------------
// brfs_pkg
// Shared types and constants for the base relocation fixup stream.
// ----------------------------------------------------------------------------
package brfs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [0:0]  CMD_START = 1'b0;
    localparam logic [3:0]  TYPE_ABS     = 4'd0;
    localparam logic [3:0]  TYPE_HIGHLOW = 4'd3;

    localparam logic [2:0]  K_PATCH       = 3'd0;
    localparam logic [2:0]  K_DONE        = 3'd1;
    localparam logic [2:0]  K_DIR_RANGE   = 3'd2;
    localparam logic [2:0]  K_BLOCK_RANGE = 3'd3;
    localparam logic [2:0]  K_BAD_TYPE    = 3'd4;

    localparam logic [2:0]  CFG_IMAGE_BASE = 3'd0;
    localparam logic [2:0]  CFG_LOAD_ADDR  = 3'd1;
    localparam logic [2:0]  CFG_IMAGE_SIZE = 3'd2;
    localparam logic [2:0]  CFG_DIR_RVA    = 3'd3;
    localparam logic [2:0]  CFG_DIR_SIZE   = 3'd4;

    // decoded item handed from front to back
    typedef struct packed {
        logic        is_start;
        logic        is_highlow;
        logic        is_skip;
        logic [15:0] halfword;
    } t_op;

    typedef struct packed {
        logic [31:0] image_base;
        logic [31:0] load_address;
        logic [31:0] image_size;
        logic [31:0] dir_rva;
        logic [31:0] dir_size;
    } t_cfg;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_PAGE_LO   = 8'b0000_0010,
        PH_PAGE_HI   = 8'b0000_0100,
        PH_SIZE_LO   = 8'b0000_1000,
        PH_SIZE_HI   = 8'b0001_0000,
        PH_ENTRY     = 8'b0010_0000,
        PH_DONE_PEND = 8'b0100_0000,
        PH_FINISHED  = 8'b1000_0000
    } t_phase;

endpackage

### src/brfs_front.sv
// ----------------------------------------------------------------------------
// brfs_front
// Accepts input items, decodes command and entry type, and queues them.
// ----------------------------------------------------------------------------
module brfs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_cmd,
    input  logic [15:0]   i_halfword,
    output logic          o_op_valid,
    output brfs_pkg::t_op o_op,
    input  logic          i_op_take
);
    import brfs_pkg::*;

    t_op             r_mem [QDEPTH];
    logic [QAW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QAW:0]    r_count, n_count;
    logic            w_push;
    logic            w_pop;
    logic [3:0]      w_type;
    t_op             w_op;

    assign w_type = i_halfword[15:12];

    always_comb begin
        w_op.is_start   = (i_cmd == CMD_START);
        w_op.is_highlow = (w_type == TYPE_HIGHLOW);
        w_op.is_skip    = (w_type == TYPE_ABS);
        w_op.halfword   = i_halfword;
    end

    assign o_stall    = (r_count == QDEPTH[QAW:0]);
    assign w_push     = i_valid && !o_stall;
    assign o_op_valid = (r_count != '0);
    assign w_pop      = i_op_take && o_op_valid;
    assign o_op       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + {{QAW{1'b0}}, w_push} - {{QAW{1'b0}}, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_op;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QDEPTH[QAW:0])
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QDEPTH[QAW:0]) && !w_pop |=> (r_count == QDEPTH[QAW:0]))
        else $error("queue count changed while full");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !w_push |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue pop lost");

endmodule

### src/brfs_back.sv
// ----------------------------------------------------------------------------
// brfs_back
// Walks the directory one queued item per cycle while no held result is stalled, and drives the result register.
// ----------------------------------------------------------------------------
module brfs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  brfs_pkg::t_cfg i_cfg,
    input  logic           i_op_valid,
    input  brfs_pkg::t_op  i_op,
    output logic           o_op_take,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [2:0]     o_kind,
    output logic [31:0]    o_target_addr,
    output logic [31:0]    o_addend
);
    import brfs_pkg::*;

    t_phase       r_phase, n_phase;
    logic [32:0]  r_position, n_position;
    logic [32:0]  r_block_end, n_block_end;
    logic [31:0]  r_page_addr, n_page_addr;
    logic [15:0]  r_hold, n_hold;
    logic         r_out_valid;
    logic [2:0]   r_kind;
    logic [31:0]  r_target, r_addend;

    logic         w_emit;
    logic [2:0]   w_kind;
    logic [31:0]  w_target;
    logic         w_take;
    logic [32:0]  w_dir_end;
    logic [32:0]  w_img_size;
    logic [32:0]  w_pos8, w_pos2, w_bend;

    assign w_dir_end  = {1'b0, i_cfg.dir_rva} + {1'b0, i_cfg.dir_size};
    assign w_img_size = {1'b0, i_cfg.image_size};
    assign w_pos8     = r_position + 33'd8;
    assign w_pos2     = r_position + 33'd2;
    assign w_bend     = r_position + {1'b0, i_op.halfword, r_hold};

    assign w_take    = i_op_valid && (!r_out_valid || !i_stall);
    assign o_op_take = w_take;

    always_comb begin
        n_phase     = r_phase;
        n_position  = r_position;
        n_block_end = r_block_end;
        n_page_addr = r_page_addr;
        n_hold      = r_hold;
        w_emit      = 1'b0;
        w_kind      = K_DONE;
        w_target    = '0;
        if (i_op.is_start) begin
            n_position  = {1'b0, i_cfg.dir_rva};
            n_block_end = '0;
            n_page_addr = '0;
            n_hold      = '0;
            if (i_cfg.dir_rva == '0 || i_cfg.dir_size == '0) begin
                n_phase = PH_FINISHED;
                w_emit  = 1'b1;
                w_kind  = K_DONE;
            end else if (w_dir_end > w_img_size) begin
                n_phase = PH_FINISHED;
                w_emit  = 1'b1;
                w_kind  = K_DIR_RANGE;
            end else begin
                n_phase = PH_PAGE_LO;
            end
        end else begin
            case (r_phase)
                PH_PAGE_LO: begin
                    n_hold  = i_op.halfword;
                    n_phase = PH_PAGE_HI;
                end
                PH_PAGE_HI: begin
                    n_page_addr = {i_op.halfword, r_hold};
                    n_phase     = PH_SIZE_LO;
                end
                PH_SIZE_LO: begin
                    n_hold  = i_op.halfword;
                    n_phase = PH_SIZE_HI;
                end
                PH_SIZE_HI: begin
                    n_block_end = w_bend;
                    n_position  = w_pos8;
                    if (w_bend > w_img_size) begin
                        n_phase = PH_FINISHED;
                        w_emit  = 1'b1;
                        w_kind  = K_BLOCK_RANGE;
                    end else if (w_pos8 < w_bend) begin
                        n_phase = PH_ENTRY;
                    end else if (w_pos8 < w_dir_end) begin
                        n_phase = PH_PAGE_LO;
                    end else begin
                        n_phase = PH_FINISHED;
                        w_emit  = 1'b1;
                        w_kind  = K_DONE;
                    end
                end
                PH_ENTRY: begin
                    n_position = w_pos2;
                    if (!i_op.is_highlow && !i_op.is_skip) begin
                        n_phase = PH_FINISHED;
                        w_emit  = 1'b1;
                        w_kind  = K_BAD_TYPE;
                    end else begin
                        if (w_pos2 >= r_block_end) begin
                            if (w_pos2 < w_dir_end) begin
                                n_phase = PH_PAGE_LO;
                            end else if (i_op.is_highlow) begin
                                n_phase = PH_DONE_PEND;
                            end else begin
                                n_phase = PH_FINISHED;
                                w_emit  = 1'b1;
                                w_kind  = K_DONE;
                            end
                        end
                        if (i_op.is_highlow) begin
                            w_emit   = 1'b1;
                            w_kind   = K_PATCH;
                            w_target = r_page_addr + {20'b0, i_op.halfword[11:0]};
                        end
                    end
                end
                PH_DONE_PEND: begin
                    n_phase = PH_FINISHED;
                    w_emit  = 1'b1;
                    w_kind  = K_DONE;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_position  <= '0;
            r_block_end <= '0;
            r_page_addr <= '0;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase     <= n_phase;
                r_position  <= n_position;
                r_block_end <= n_block_end;
                r_page_addr <= n_page_addr;
                r_hold      <= n_hold;
            end
            if (w_take && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_kind   <= w_kind;
            r_target <= w_target;
            r_addend <= (w_kind == K_PATCH) ?
                        (i_cfg.load_address - i_cfg.image_base) : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_target_addr = r_target;
    assign o_addend      = r_addend;

    a_entry_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ENTRY) |-> (r_position < r_block_end))
        else $error("entry phase past block end");

    a_done_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE_PEND) && !$past(r_phase == PH_DONE_PEND)
        |-> $past(r_phase == PH_ENTRY))
        else $error("done pending without a closing patch");

    a_non_patch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind != K_PATCH) |-> (r_target == '0) && (r_addend == '0))
        else $error("non-patch result carries data");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_kind <= K_BAD_TYPE))
        else $error("illegal result kind");

endmodule

### src/base_relocation_fixup_stream.sv
// ----------------------------------------------------------------------------
// base_relocation_fixup_stream
// Walks a base relocation directory given as halfwords and emits HIGHLOW
// patches, done and error results.
// ----------------------------------------------------------------------------
// Each item is a start command or one directory halfword, and gives at most
// one result. The block takes one item per cycle while the queue is not full:
// the front decodes items into a four-entry queue, the back executes one queued
// item per cycle unless a held result is stalled (its phase, position, block
// end, page and hold registers form its loop) and loads a result register.
// A stall on the result side fills the queue before the input is stalled.
// Configuration writes are always ready and take effect on the next cycle.
module base_relocation_fixup_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_halfword,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_target_addr,
    output logic [31:0] o_addend,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import brfs_pkg::*;

    t_cfg  r_cfg;
    logic  w_cfg_wr;
    logic  w_op_valid;
    logic  w_op_take;
    t_op   w_op;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_IMAGE_BASE: r_cfg.image_base   <= i_cfg_data;
                CFG_LOAD_ADDR:  r_cfg.load_address <= i_cfg_data;
                CFG_IMAGE_SIZE: r_cfg.image_size   <= i_cfg_data;
                CFG_DIR_RVA:    r_cfg.dir_rva      <= i_cfg_data;
                CFG_DIR_SIZE:   r_cfg.dir_size     <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    brfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_halfword (i_halfword),
        .o_op_valid (w_op_valid),
        .o_op       (w_op),
        .i_op_take  (w_op_take)
    );

    brfs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_op_valid    (w_op_valid),
        .i_op          (w_op),
        .o_op_take     (w_op_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_target_addr (o_target_addr),
        .o_addend      (o_addend)
    );

endmodule
